// ----- rtl/fss_pkg.sv -----
// Package for the frame stack with static links: sizes, operation and status codes,
// and the sequencer state type.
// Depends on nothing; every rtl file imports it.
package fss_pkg;

   localparam int MEM_WORDS = 1024;
   localparam int MAX_NEST  = 15;
   localparam int ADDR_W    = $clog2(MEM_WORDS);
   localparam int WORD_W    = 32;
   localparam int DIST_W    = 4;
   localparam int NEWTOP_W  = ADDR_W + 2;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_ENTER = 2'd2,
      MODE_LEAVE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_OVER  = 2'd1,
      STATUS_UNDER = 2'd2,
      STATUS_FAULT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_WALK_WAIT,
      ST_DL_WAIT,
      ST_RD_WAIT,
      ST_ENTER2,
      ST_LEAVE_WAIT,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/frame_stack_static_link_core.sv -----
// Activation-record stack with static and dynamic chains in a 1024-word store; top level,
// depends on fss_pkg. Reset is synchronous, active high, and starts a clearing pass over all
// MEM_WORDS (1024) words of the store, during which no item is accepted.
// Each static link followed costs one read and one wait state on the memory's single read port.
// Throughput: one item at a time, accepted the cycle after the previous result is loaded.
module frame_stack_static_link_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_nest_distance,
   input  logic [9:0]  req_local_offset,
   input  logic signed [31:0] req_write_value,
   input  logic [9:0]  req_frame_locals,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_read_data,
   output logic [1:0]  rsp_status
);
   import fss_pkg::*;

   // Sequencer and item registers.
   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [DIST_W-1:0]     cnt_ff, cnt_in;
   logic [WORD_W-1:0]     p_ff, p_in;
   logic [ADDR_W-1:0]     off_ff, off_in;
   logic [WORD_W-1:0]     wval_ff, wval_in;
   logic [ADDR_W-1:0]     nloc_ff, nloc_in;
   logic [ADDR_W-1:0]     newtop_ff, newtop_in;
   logic [ADDR_W-1:0]     frame_top_ff, frame_top_in;
   logic [ADDR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [WORD_W-1:0]     res_data_ff, res_data_in;
   status_type            res_status_ff, res_status_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;

   // Memory port.
   logic [WORD_W-1:0]     store_mem [MEM_WORDS];
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [WORD_W-1:0]     mem_wdata;
   logic                  mem_re;
   logic [ADDR_W-1:0]     mem_raddr;
   logic [WORD_W-1:0]     mem_rdata_ff;

   // Combinational helpers.
   logic                  accept;
   logic [NEWTOP_W-1:0]   newtop_sum;
   logic [ADDR_W-1:0]     base_addr;
   logic [ADDR_W-1:0]     local_addr;
   logic [ADDR_W-1:0]     top_minus1;

   assign req_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

   // The new frame's top word sits past the current top, its locals and the two links.
   assign newtop_sum = NEWTOP_W'(frame_top_ff) + NEWTOP_W'(nloc_ff) + NEWTOP_W'(2);
   // Address of the word just below the reached frame's dynamic link.
   assign base_addr  = p_ff[ADDR_W-1:0] - ADDR_W'(2);
   assign local_addr = base_addr - off_ff;
   assign top_minus1 = frame_top_ff - ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         frame_top_ff  <= '0;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frame_top_ff  <= frame_top_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      cnt_ff        <= cnt_in;
      p_ff          <= p_in;
      off_ff        <= off_in;
      wval_ff       <= wval_in;
      nloc_ff       <= nloc_in;
      newtop_ff     <= newtop_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Single write port, single registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_raddr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cnt_in        = cnt_ff;
      p_in          = p_ff;
      off_in        = off_ff;
      wval_in       = wval_ff;
      nloc_in       = nloc_ff;
      newtop_in     = newtop_ff;
      frame_top_in  = frame_top_ff;
      clr_cnt_in    = clr_cnt_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;

      // The output register empties independently of the sequencer.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // Clearing pass: one word per cycle, the whole store.
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               mode_in       = mode_type'(req_mode);
               cnt_in        = req_nest_distance;
               p_in          = WORD_W'(frame_top_ff);
               off_in        = req_local_offset;
               wval_in       = req_write_value;
               nloc_in       = req_frame_locals;
               res_data_in   = '0;
               res_status_in = STATUS_OK;
               if (mode_type'(req_mode) == MODE_LEAVE) begin
                  if (frame_top_ff == '0) begin
                     res_status_in = STATUS_UNDER;
                     state_in      = ST_DONE;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = top_minus1;
                     state_in  = ST_LEAVE_WAIT;
                  end
               end else if (32'(req_nest_distance) > 32'(MAX_NEST)) begin
                  res_status_in = STATUS_FAULT;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (cnt_ff != '0) begin
               // One static link per visit; leaving the outermost frame is a fault.
               if (p_ff == '0 || p_ff >= WORD_W'(MEM_WORDS)) begin
                  res_status_in = STATUS_FAULT;
                  state_in      = ST_DONE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = p_ff[ADDR_W-1:0];
                  state_in  = ST_WALK_WAIT;
               end
            end else if (p_ff >= WORD_W'(MEM_WORDS)) begin
               res_status_in = STATUS_FAULT;
               state_in      = ST_DONE;
            end else if (mode_ff == MODE_ENTER) begin
               if (newtop_sum > NEWTOP_W'(MEM_WORDS - 1)) begin
                  res_status_in = STATUS_OVER;
                  state_in      = ST_DONE;
               end else begin
                  // Static link goes to the new top word.
                  newtop_in = newtop_sum[ADDR_W-1:0];
                  mem_we    = 1'b1;
                  mem_waddr = newtop_sum[ADDR_W-1:0];
                  mem_wdata = p_ff;
                  state_in  = ST_ENTER2;
               end
            end else if (p_ff < WORD_W'(2)) begin
               // No frame was reached, so there are no locals to address.
               res_status_in = STATUS_FAULT;
               state_in      = ST_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = p_ff[ADDR_W-1:0] - ADDR_W'(1);
               state_in  = ST_DL_WAIT;
            end
         end

         ST_WALK_WAIT: begin
            p_in     = mem_rdata_ff;
            cnt_in   = cnt_ff - DIST_W'(1);
            state_in = ST_WALK;
         end

         ST_DL_WAIT: begin
            // The local must lie strictly above the previous frame top that the dynamic link holds.
            if (off_ff > base_addr
                || WORD_W'(local_addr) <= mem_rdata_ff) begin
               res_status_in = STATUS_FAULT;
               state_in      = ST_DONE;
            end else if (mode_ff == MODE_WRITE) begin
               mem_we    = 1'b1;
               mem_waddr = local_addr;
               mem_wdata = wval_ff;
               state_in  = ST_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = local_addr;
               state_in  = ST_RD_WAIT;
            end
         end

         ST_RD_WAIT: begin
            res_data_in = mem_rdata_ff;
            state_in    = ST_DONE;
         end

         ST_ENTER2: begin
            // Dynamic link goes just below the static link.
            mem_we       = 1'b1;
            mem_waddr    = newtop_ff - ADDR_W'(1);
            mem_wdata    = WORD_W'(frame_top_ff);
            frame_top_in = newtop_ff;
            state_in     = ST_DONE;
         end

         ST_LEAVE_WAIT: begin
            // A dynamic link not below the frame is corrupt; zero always pops to empty.
            if (mem_rdata_ff >= WORD_W'(top_minus1) && mem_rdata_ff != '0) begin
               res_status_in = STATUS_FAULT;
            end else begin
               frame_top_in = mem_rdata_ff[ADDR_W-1:0];
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // No item may enter while the store is still being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("item accepted during clearing pass");

   // The frame top moves only when an enter or a leave completes.
   a_top_moves_on_frame_ops: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(frame_top_ff))
      |-> ($past(state_ff) == ST_ENTER2 || $past(state_ff) == ST_LEAVE_WAIT))
      else $error("frame top changed outside enter or leave");

   // The chain walk never waits on a link it was not allowed to follow.
   a_walk_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_WAIT) |-> (cnt_ff != '0))
      else $error("walk counter underflow");

   // Word zero is never part of a frame, so only the clearing pass writes it.
   a_word_zero_untouched: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff != ST_CLEAR) |-> (mem_waddr != '0))
      else $error("write to word zero outside clearing pass");

endmodule
